/* hdl/sfxh_pkg.sv */
`timescale 1ns / 1ps

package sfxh_pkg;

  // Key folding constants.
  localparam int unsigned MAX_KEY_BYTES = 256;
  localparam int unsigned TAKEN_W       = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned HASH_W        = 16;
  localparam logic [HASH_W-1:0] HASH_SEED        = 16'h5AB6;
  localparam logic [HASH_W-1:0] TABLE_SIZE_RESET = 16'd8191;

  // Queue between the folding front end and the modulo back end.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Modulo unit: one quotient bit per cycle.
  localparam int unsigned DIV_CNT_W = $clog2(HASH_W);

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hdl/sfxh_in_if.sv */
`timescale 1ns / 1ps

interface sfxh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last_byte;

  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

/* hdl/sfxh_out_if.sv */
`timescale 1ns / 1ps

interface sfxh_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_hash;
  logic [15:0] bucket_index;

  modport source (output valid, output raw_hash, output bucket_index, input ready);
  modport sink (input valid, input raw_hash, input bucket_index, output ready);
endinterface

/* hdl/string_fold_xor_hash.sv */
`timescale 1ns / 1ps

// Folding XOR hash of byte keys with a bucket index.
// Key bytes arrive on key_i (valid/ready), one transfer per byte, with
// last_byte set on the final byte of each key. A byte is taken whenever
// key_i is ready, which it is while the queue is not full.
// On the last byte the finished hash enters a two-entry queue. The modulo
// unit behind it takes one quotient bit per cycle and works on one hash at a
// time: queue entry, divider registers, then the output register.
// Keys of 18 bytes or more stream without input stalls while hash_o is not
// stalled; shorter keys are throttled by the modulo unit once the queue fills.
// hash_o carries raw_hash and bucket_index (raw_hash modulo table_size, or
// zero for a table size of zero) in a registered transfer. While the receiver
// stalls, the result holds, the next key keeps folding and the queue absorbs
// up to two more results before key_i deasserts ready.
// cfg_we_i writes table_size; write it only while no key is in flight.
// Reset clears all key state, empties the queue and sets table_size to 8191.

module string_fold_xor_hash
  import sfxh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  sfxh_in_if.sink           key_i,
  sfxh_out_if.source        hash_o,
  input  logic              cfg_we_i,
  input  logic [HASH_W-1:0] cfg_data_i
);

  logic [HASH_W-1:0] table_size_q;
  q_status_t         q_status;
  logic              push;
  logic [HASH_W-1:0] push_hash;
  logic              pop;
  logic [HASH_W-1:0] q_hash;

  // Table size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RESET;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_data_i;
    end
  end

  // Front end: folds bytes into the running hash.
  sfxh_fold u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (key_i.valid),
    .ready_o     (key_i.ready),
    .key_byte_i  (key_i.key_byte),
    .last_byte_i (key_i.last_byte),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_hash_o (push_hash)
  );

  // Queue of finished hashes.
  sfxh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_hash_i (push_hash),
    .pop_i       (pop),
    .pop_hash_o  (q_hash),
    .status_o    (q_status)
  );

  // Back end: modulo and output register.
  sfxh_mod u_mod (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .table_size_i   (table_size_q),
    .q_status_i     (q_status),
    .q_hash_i       (q_hash),
    .pop_o          (pop),
    .valid_o        (hash_o.valid),
    .ready_i        (hash_o.ready),
    .raw_hash_o     (hash_o.raw_hash),
    .bucket_index_o (hash_o.bucket_index)
  );

endmodule

/* hdl/sfxh_fold.sv */
`timescale 1ns / 1ps

module sfxh_fold
  import sfxh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [BYTE_W-1:0] key_byte_i,
  input  logic              last_byte_i,
  input  q_status_t         q_status_i,
  output logic              push_o,
  output logic [HASH_W-1:0] push_hash_o
);

  logic [HASH_W-1:0]  hash_q, hash_d;
  logic [BYTE_W-1:0]  pend_q, pend_d;
  logic               have_q, have_d;
  logic               shift_q, shift_d;
  logic [TAKEN_W-1:0] taken_q, taken_d;
  logic               accept;
  logic [HASH_W-1:0]  word;

  // A byte is taken whenever the queue has room for a possible result.
  assign ready_o = !q_status_i.full;
  assign accept  = valid_i && ready_o;

  // Fold one byte into the key state.
  always_comb begin
    hash_d  = hash_q;
    pend_d  = pend_q;
    have_d  = have_q;
    shift_d = shift_q;
    taken_d = taken_q;
    word    = {key_byte_i, pend_q};
    if (shift_q) begin
      word = {word[HASH_W-2:0], 1'b0};
    end
    if (accept && (taken_q < TAKEN_W'(MAX_KEY_BYTES))) begin
      taken_d = taken_q + TAKEN_W'(1);
      if (have_q) begin
        hash_d  = hash_q ^ word;
        shift_d = !shift_q;
        have_d  = 1'b0;
        pend_d  = '0;
      end else begin
        pend_d = key_byte_i;
        have_d = 1'b1;
      end
    end
  end

  // The last byte closes the key: a left-over byte is doubled and folded in.
  assign push_o      = accept && last_byte_i;
  assign push_hash_o = have_d ? (hash_d ^ {pend_d, pend_d}) : hash_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= HASH_SEED;
      pend_q  <= '0;
      have_q  <= 1'b0;
      shift_q <= 1'b0;
      taken_q <= '0;
    end else if (push_o) begin
      hash_q  <= HASH_SEED;
      pend_q  <= '0;
      have_q  <= 1'b0;
      shift_q <= 1'b0;
      taken_q <= '0;
    end else begin
      hash_q  <= hash_d;
      pend_q  <= pend_d;
      have_q  <= have_d;
      shift_q <= shift_d;
      taken_q <= taken_d;
    end
  end

endmodule

/* hdl/sfxh_queue.sv */
`timescale 1ns / 1ps

module sfxh_queue
  import sfxh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [HASH_W-1:0] push_hash_i,
  input  logic              pop_i,
  output logic [HASH_W-1:0] pop_hash_o,
  output q_status_t         status_o
);

  logic [HASH_W-1:0] entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_hash_o     = entry_q[rd_ptr_q];

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_hash_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/sfxh_mod.sv */
`timescale 1ns / 1ps

module sfxh_mod
  import sfxh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [HASH_W-1:0] table_size_i,
  input  q_status_t         q_status_i,
  input  logic [HASH_W-1:0] q_hash_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [HASH_W-1:0] raw_hash_o,
  output logic [HASH_W-1:0] bucket_index_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [HASH_W-1:0]    hash_q, hash_d;
  logic [HASH_W-1:0]    dvd_q, dvd_d;
  logic [HASH_W-1:0]    dvs_q, dvs_d;
  logic [HASH_W-1:0]    rem_q, rem_d;
  logic                 out_valid_q, out_valid_d;
  logic [HASH_W-1:0]    out_hash_q, out_hash_d;
  logic [HASH_W-1:0]    out_bucket_q, out_bucket_d;
  logic [HASH_W:0]      trial;
  logic [HASH_W-1:0]    rem_step;
  logic                 out_free;

  assign valid_o        = out_valid_q;
  assign raw_hash_o     = out_hash_q;
  assign bucket_index_o = out_bucket_q;
  assign out_free       = !out_valid_q || ready_i;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // A zero divisor leaves the dividend in the remainder, so the output stage
  // replaces it by zero.
  always_comb begin
    trial    = {rem_q, dvd_q[HASH_W-1]};
    rem_step = (trial >= {1'b0, dvs_q}) ? HASH_W'(trial - {1'b0, dvs_q}) : trial[HASH_W-1:0];
  end

  // Sequencer for the modulo and the output register.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    hash_d       = hash_q;
    dvd_d        = dvd_q;
    dvs_d        = dvs_q;
    rem_d        = rem_q;
    out_hash_d   = out_hash_q;
    out_bucket_d = out_bucket_q;
    out_valid_d  = out_valid_q && !ready_i;
    pop_o        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          hash_d  = q_hash_i;
          dvd_d   = q_hash_i;
          dvs_d   = table_size_i;
          rem_d   = '0;
          cnt_d   = DIV_CNT_W'(HASH_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = rem_step;
        dvd_d = {dvd_q[HASH_W-2:0], 1'b0};
        cnt_d = cnt_q - DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_hash_d   = hash_q;
          out_bucket_d = (dvs_q == '0) ? '0 : rem_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    hash_q       <= hash_d;
    dvd_q        <= dvd_d;
    dvs_q        <= dvs_d;
    rem_q        <= rem_d;
    out_hash_q   <= out_hash_d;
    out_bucket_q <= out_bucket_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
